// File: sv/awb_pkg.sv
// Package for the AWB OTP gain calculation core.
// Types and constants shared by the top level and the checker; no dependencies.
package awb_pkg;

	localparam int unsigned DivW = 32;
	localparam logic [15:0] UnityGain = 16'h1000;
	localparam logic [15:0] Q9One = 16'd512;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_ZERO_IN   = 2'd1,
		ST_ZERO_RAT  = 2'd2
	} status_t;

	// sideband that travels with the green candidate divisions
	typedef struct packed {
		logic    r_big;
		logic    b_big;
		status_t st;
	} side_t;

endpackage

// File: sv/awb_div.sv
// Pipelined restoring divider: 32-bit numerator by 16-bit denominator, four
// quotient bits per stage, NumW/4 stall-able register stages.
module awb_div #(
	parameter int unsigned NumW = 32,
	parameter int unsigned DenW = 16,
	parameter int unsigned TagW = 8
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_v,
	input  logic [NumW-1:0] num_a,
	input  logic [DenW-1:0] den_a,
	input  logic [NumW-1:0] num_b,
	input  logic [DenW-1:0] den_b,
	input  logic [TagW-1:0] tag_in,
	output logic            out_v,
	output logic [NumW-1:0] quo_a,
	output logic [NumW-1:0] quo_b,
	output logic [TagW-1:0] tag_out
);
	localparam int unsigned Stages = NumW / 4;

	logic            v_s [Stages+1];
	logic [NumW-1:0] qa_s [Stages+1];
	logic [NumW-1:0] qb_s [Stages+1];
	logic [DenW:0]   ra_s [Stages+1];
	logic [DenW:0]   rb_s [Stages+1];
	logic [DenW-1:0] da_s [Stages+1];
	logic [DenW-1:0] db_s [Stages+1];
	logic [TagW-1:0] t_s  [Stages+1];

	assign v_s[0]  = in_v;
	assign qa_s[0] = num_a;
	assign qb_s[0] = num_b;
	assign ra_s[0] = '0;
	assign rb_s[0] = '0;
	assign da_s[0] = den_a;
	assign db_s[0] = den_b;
	assign t_s[0]  = tag_in;

	for (genvar g = 0; g < Stages; g++) begin : g_stage
		logic [NumW-1:0] qa, qb;
		logic [DenW:0]   ra, rb;
		// four quotient bits per stage for both lanes
		always_comb begin
			logic [DenW+1:0] ta, tb;
			qa = qa_s[g];
			qb = qb_s[g];
			ra = ra_s[g];
			rb = rb_s[g];
			for (int k = 0; k < 4; k++) begin
				ta = {ra, qa[NumW-1]};
				tb = {rb, qb[NumW-1]};
				qa = {qa[NumW-2:0], 1'b0};
				qb = {qb[NumW-2:0], 1'b0};
				if (ta >= {2'b00, da_s[g]}) begin
					ta = ta - {2'b00, da_s[g]};
					qa[0] = 1'b1;
				end
				if (tb >= {2'b00, db_s[g]}) begin
					tb = tb - {2'b00, db_s[g]};
					qb[0] = 1'b1;
				end
				ra = ta[DenW:0];
				rb = tb[DenW:0];
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[g+1] <= 1'b0;
			end else if (en) begin
				v_s[g+1] <= v_s[g];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				qa_s[g+1] <= qa;
				qb_s[g+1] <= qb;
				ra_s[g+1] <= ra;
				rb_s[g+1] <= rb;
				da_s[g+1] <= da_s[g];
				db_s[g+1] <= db_s[g];
				t_s[g+1]  <= t_s[g];
			end
		end
	end

	assign out_v   = v_s[Stages];
	assign quo_a   = qa_s[Stages];
	assign quo_b   = qb_s[Stages];
	assign tag_out = t_s[Stages];
endmodule

// File: sv/awb_otp_gain_calc_core.sv
// Top level of the AWB OTP gain calculation core.
// Uses awb_pkg and three awb_div pipelines.
//
// Fully pipelined: a new transaction is accepted every cycle unless the output
// stalls. The path runs through the ratio divider, then the gain dividers
// (which run in parallel), each retiring four quotient bits per stage, then
// the output register. Both green candidates and both scaled gains are
// divided out, and the unity channel is picked at the end.
// The whole pipe advances when the output register is empty or being taken.
module awb_otp_gain_calc_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [15:0] meas_rg,
	input  logic [15:0] meas_bg,
	input  logic [15:0] gold_rg,
	input  logic [15:0] gold_bg,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [15:0] red_gain,
	output logic [15:0] green_gain,
	output logic [15:0] blue_gain
);
	localparam int unsigned W = awb_pkg::DivW;
	localparam int unsigned SW = $bits(awb_pkg::side_t);
	// 4096*512, numerator of both green candidates
	localparam logic [W-1:0] GreenNum = 32'h0020_0000;

	logic en;
	assign en = !out_valid || out_ready;
	assign in_ready = en;

	// stage 1: ratio division, zero-input flag as tag
	logic zin;
	assign zin = (meas_rg == '0) || (meas_bg == '0) || (gold_rg == '0) || (gold_bg == '0);

	logic          v1;
	logic [W-1:0]  qr, qb;
	logic [0:0]    zin1;
	awb_div #(.NumW(W), .DenW(16), .TagW(1)) u_div_ratio (
		.clk, .arst_n, .en,
		.in_v   (in_valid),
		.num_a  ({7'd0, gold_rg, 9'd0}),
		.den_a  (zin ? 16'd1 : meas_rg),
		.num_b  ({7'd0, gold_bg, 9'd0}),
		.den_b  (zin ? 16'd1 : meas_bg),
		.tag_in (zin),
		.out_v  (v1), .quo_a(qr), .quo_b(qb), .tag_out(zin1)
	);

	// stage 2 setup: status, branch flags and guarded divisors
	awb_pkg::side_t sd;
	logic [15:0] r, b, dr, db;
	always_comb begin
		r = qr[15:0];
		b = qb[15:0];
		sd.r_big = (r >= awb_pkg::Q9One);
		sd.b_big = (b >= awb_pkg::Q9One);
		if (zin1[0])                      sd.st = awb_pkg::ST_ZERO_IN;
		else if (r == '0 || b == '0)      sd.st = awb_pkg::ST_ZERO_RAT;
		else                              sd.st = awb_pkg::ST_OK;
		dr = (r == '0) ? 16'd1 : r;
		db = (b == '0) ? 16'd1 : b;
	end

	// green candidates 4096*512/r and 4096*512/b
	logic         v2;
	logic [W-1:0] qgr, qgb;
	logic [SW-1:0] sdo;
	awb_div #(.NumW(W), .DenW(16), .TagW(SW)) u_div_green (
		.clk, .arst_n, .en,
		.in_v(v1), .num_a(GreenNum), .den_a(dr), .num_b(GreenNum), .den_b(db),
		.tag_in(sd), .out_v(v2), .quo_a(qgr), .quo_b(qgb), .tag_out(sdo)
	);

	// scaled gains 4096*b/r and 4096*r/b, ratios as tag
	logic         v2x;
	logic [W-1:0] qbr, qrb;
	logic [31:0]  rbo;
	awb_div #(.NumW(W), .DenW(16), .TagW(32)) u_div_scale (
		.clk, .arst_n, .en,
		.in_v(v1), .num_a({4'd0, b, 12'd0}), .den_a(dr),
		.num_b({4'd0, r, 12'd0}), .den_b(db),
		.tag_in({r, b}), .out_v(v2x), .quo_a(qbr), .quo_b(qrb), .tag_out(rbo)
	);

	// final select and output register
	awb_pkg::side_t s2;
	logic [15:0] r2, b2;
	logic red_unity;
	logic [15:0] rg, gg, bg;
	always_comb begin
		s2 = awb_pkg::side_t'(sdo);
		r2 = rbo[31:16];
		b2 = rbo[15:0];
		if (s2.r_big)      red_unity = 1'b0;
		else if (s2.b_big) red_unity = 1'b1;
		else               red_unity = (qgr[15:0] >= qgb[15:0]);
		if (s2.st != awb_pkg::ST_OK) begin
			rg = '0; gg = '0; bg = '0;
		end else if (s2.r_big && s2.b_big) begin
			rg = {r2[12:0], 3'd0};
			gg = awb_pkg::UnityGain;
			bg = {b2[12:0], 3'd0};
		end else if (red_unity) begin
			rg = awb_pkg::UnityGain;
			gg = qgr[15:0];
			bg = qbr[15:0];
		end else begin
			rg = qrb[15:0];
			gg = qgb[15:0];
			bg = awb_pkg::UnityGain;
		end
	end

	logic [1:0]  st_q;
	logic [15:0] rg_q, gg_q, bg_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= v2 && v2x;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			st_q <= s2.st;
			rg_q <= rg;
			gg_q <= gg;
			bg_q <= bg;
		end
	end
	assign status     = st_q;
	assign red_gain   = rg_q;
	assign green_gain = gg_q;
	assign blue_gain  = bg_q;
endmodule

// File: sv/awb_chk.sv
// Port-level checker for awb_otp_gain_calc_core, with its bind.
// Depends on the top level's ports and on awb_pkg.
module awb_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  status,
	input logic [15:0] red_gain,
	input logic [15:0] green_gain,
	input logic [15:0] blue_gain
);
	// a stalled result transaction holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(red_gain) && $stable(status))
		else $error("result changed while stalled");
	// error status carries zero gains
	a_err: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != awb_pkg::ST_OK |->
		red_gain == 0 && green_gain == 0 && blue_gain == 0)
		else $error("error result with nonzero gain");
	// ok status keeps one channel at unity
	a_unity: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == awb_pkg::ST_OK |->
		red_gain == awb_pkg::UnityGain || green_gain == awb_pkg::UnityGain ||
		blue_gain == awb_pkg::UnityGain)
		else $error("no unity channel");
	// input backpressure only when a result is stalled
	a_rdy: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without output stall");
endmodule

bind awb_otp_gain_calc_core awb_chk u_awb_chk (
	.clk, .arst_n, .in_ready, .out_valid, .out_ready,
	.status, .red_gain, .green_gain, .blue_gain
);
